### rtl/assert_macros.svh
// Assertion macros shared by the heavy hitter RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in every cycle where ante holds, outside reset.
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check expr in every cycle outside reset.
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`endif

### rtl/sshh_pkg.sv
// Shared constants, types and helpers for the heavy hitter counter.
// No dependencies; used by sshh_table and space_saving_heavy_hitters_unit.
`timescale 1ns / 1ps

package sshh_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int OCC_W       = $clog2(TABLE_SLOTS + 1);
  localparam int ENTRY_W     = KEY_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Write-back request from the sequencer to the table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic              set_valid;
  } wr_req_t;

  // Outcome of one full table scan.
  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] match_slot;
    logic [CNT_W-1:0]  match_count;
    logic              have_free;
    logic [SLOT_W-1:0] free_slot;
    logic              have_min;
    logic [SLOT_W-1:0] min_slot;
    logic [KEY_W-1:0]  min_key;
    logic [CNT_W-1:0]  min_count;
  } scan_res_t;

  // Saturating increment of a count.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

endpackage

### rtl/sshh_table.sv
// Slot table: key/count memory, valid bits, occupancy and the scan engine.
// Depends on sshh_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module sshh_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sshh_pkg::KEY_W-1:0] key,
  input  sshh_pkg::wr_req_t        wr,
  output sshh_pkg::scan_res_t      res
);
  import sshh_pkg::*;
  `include "assert_macros.svh"

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [ENTRY_W-1:0]     mem [TABLE_SLOTS];
  logic [ENTRY_W-1:0]     mem_q;
  logic [TABLE_SLOTS-1:0] valid;
  logic [OCC_W-1:0]       occupied;

  logic              issuing;
  logic [SLOT_W-1:0] issue_idx;
  logic              proc_vld;
  logic [SLOT_W-1:0] proc_idx;
  logic              done;

  logic              found;
  logic [SLOT_W-1:0] match_slot;
  logic [CNT_W-1:0]  match_count;
  logic              have_free;
  logic [SLOT_W-1:0] free_slot;
  logic              have_min;
  logic [SLOT_W-1:0] min_slot;
  logic [KEY_W-1:0]  min_key;
  logic [CNT_W-1:0]  min_count;

  logic [KEY_W-1:0]  ent_key;
  logic [CNT_W-1:0]  ent_cnt;

  assign ent_key = mem_q[ENTRY_W-1 -: KEY_W];
  assign ent_cnt = mem_q[CNT_W-1:0];

  // single-port style memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= {wr.key, wr.count};
    end
    mem_q <= mem[issue_idx];
  end

  // address sweep and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_idx <= '0;
      proc_vld  <= 1'b0;
      proc_idx  <= '0;
      done      <= 1'b0;
    end else begin
      proc_vld <= issuing;
      proc_idx <= issue_idx;
      done     <= proc_vld && (proc_idx == LAST_SLOT);
      if (start) begin
        issuing   <= 1'b1;
        issue_idx <= '0;
      end else if (issuing) begin
        issue_idx <= issue_idx + SLOT_W'(1);
        if (issue_idx == LAST_SLOT) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // match, first free and minimum count, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      have_free <= 1'b0;
      have_min  <= 1'b0;
    end else if (start) begin
      found     <= 1'b0;
      have_free <= 1'b0;
      have_min  <= 1'b0;
    end else if (proc_vld) begin
      if (valid[proc_idx]) begin
        if (!found && (ent_key == key)) begin
          found       <= 1'b1;
          match_slot  <= proc_idx;
          match_count <= ent_cnt;
        end
        if (!have_min || (ent_cnt < min_count)) begin
          have_min  <= 1'b1;
          min_slot  <= proc_idx;
          min_key   <= ent_key;
          min_count <= ent_cnt;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_slot <= proc_idx;
      end
    end
  end

  // valid bits and occupancy follow each write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occupied <= '0;
    end else if (wr.en) begin
      valid[wr.slot] <= wr.set_valid;
      if (!valid[wr.slot] && wr.set_valid) begin
        occupied <= occupied + OCC_W'(1);
      end else if (valid[wr.slot] && !wr.set_valid) begin
        occupied <= occupied - OCC_W'(1);
      end
    end
  end

  assign res.done        = done;
  assign res.found       = found;
  assign res.match_slot  = match_slot;
  assign res.match_count = match_count;
  assign res.have_free   = have_free;
  assign res.free_slot   = free_slot;
  assign res.have_min    = have_min;
  assign res.min_slot    = min_slot;
  assign res.min_key     = min_key;
  assign res.min_count   = min_count;

  `CHK_ALWAYS(a_occ_matches_valid, occupied == OCC_W'($countones(valid)))
  `CHK_IMPLY(a_free_iff_not_full, done, have_free == (occupied != OCC_W'(TABLE_SLOTS)))

endmodule

### rtl/space_saving_heavy_hitters_unit.sv
// Top level of the space-saving heavy hitter counter: sequencer, threshold
// register and result register. Depends on sshh_pkg, sshh_table, assert_macros.svh.
`timescale 1ns / 1ps
//
//   channel    signals                               dir   word
//   key        key_valid, key_stall, key             in    one 32-bit key
//   result     result_valid, result_stall, hit,      out   one update outcome
//              evicted, evicted_key, key_count, reported
//   config     cfg_we, cfg_wdata                      in    report threshold
//
// The scan reads the key/count memory one slot per cycle through its single
// read port; then the sequencer picks the slot and writes it back once the
// result register can take the outcome.
// rst is synchronous: valid bits, occupancy and the sequencer clear at once,
// the threshold returns to all ones. Memory contents are left as they are.
// A stalled result holds the write-back until the result register frees up;
// a new key is taken while a finished result still waits downstream.

module space_saving_heavy_hitters_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        key_valid,
  output logic                        key_stall,
  input  logic [sshh_pkg::KEY_W-1:0]  key,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        hit,
  output logic                        evicted,
  output logic [sshh_pkg::KEY_W-1:0]  evicted_key,
  output logic [sshh_pkg::CNT_W-1:0]  key_count,
  output logic                        reported,
  input  logic                        cfg_we,
  input  logic [sshh_pkg::CNT_W-1:0]  cfg_wdata
);
  import sshh_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  threshold;

  scan_res_t         res;
  wr_req_t           wr;

  logic              accept;
  logic              commit;
  logic [SLOT_W-1:0] sel_slot;
  logic [CNT_W-1:0]  new_count;
  logic              sel_hit;
  logic              sel_evict;
  logic [KEY_W-1:0]  sel_evicted_key;
  logic              sel_report;

  // Take a key only when no item is in flight.
  assign key_stall = (state != ST_IDLE);
  assign accept    = key_valid && !key_stall;
  // Write back once the result register can take the outcome.
  assign commit    = (state == ST_DONE) && (!result_valid || !result_stall);

  sshh_table u_table (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (key_q),
    .wr    (wr),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '1;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept)     state_next = ST_SCAN;
      ST_SCAN: if (res.done)   state_next = ST_DONE;
      ST_DONE: if (commit)     state_next = ST_IDLE;
      default:                 state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the slot: tracked key first, then lowest free slot, else evict
  // the lowest-numbered entry with the smallest count.
  always_comb begin
    sel_hit         = 1'b0;
    sel_evict       = 1'b0;
    sel_evicted_key = '0;
    if (res.found) begin
      sel_slot  = res.match_slot;
      new_count = sat_inc(res.match_count);
      sel_hit   = 1'b1;
    end else if (res.have_free) begin
      sel_slot  = res.free_slot;
      new_count = CNT_ONE;
    end else begin
      sel_slot        = res.min_slot;
      new_count       = sat_inc(res.min_count);
      sel_evict       = 1'b1;
      sel_evicted_key = res.min_key;
    end
    sel_report = (new_count > threshold);
  end

  // A reported key frees its slot in the same write.
  assign wr.en        = commit;
  assign wr.slot      = sel_slot;
  assign wr.key       = key_q;
  assign wr.count     = new_count;
  assign wr.set_valid = !sel_report;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= sel_hit;
      evicted     <= sel_evict;
      evicted_key <= sel_evicted_key;
      key_count   <= new_count;
      reported    <= sel_report;
    end
  end

  `CHK_IMPLY(a_done_only_in_scan, res.done, state == ST_SCAN)
  `CHK_IMPLY(a_evict_has_min, commit && !res.found && !res.have_free, res.have_min)

endmodule

### verif/tb.sv
// Self-checking bench for space_saving_heavy_hitters_unit: directed cases, then skewed
// random key streams under several report thresholds, each result checked against a model.
// Depends on sshh_pkg and the RTL of the counter.
`timescale 1ns / 1ps

module tb;
  import sshh_pkg::*;

  // One key takes the scan of every slot plus the write-back.
  localparam int ITEM_CYCLES = TABLE_SLOTS + 4;
  // Bound on the whole run, with a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOW_LIMIT  = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_KEYS  = 190;
  localparam int POOL_MAX    = 128;

  // Outcome of one counted key, in port order.
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] key_count;
    logic             reported;
  } outcome_t;

  logic             clk;
  logic             rst;
  logic             key_valid;
  logic             key_stall;
  logic [KEY_W-1:0] key;
  logic             result_valid;
  logic             result_stall;
  logic             hit;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [CNT_W-1:0] key_count;
  logic             reported;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // Shadow of the counting table and of the threshold register.
  logic [KEY_W-1:0] slot_keys   [TABLE_SLOTS];
  logic [CNT_W-1:0] slot_counts [TABLE_SLOTS];
  logic             slot_used   [TABLE_SLOTS];
  logic [CNT_W-1:0] report_limit;

  outcome_t         pending_outcomes[$];
  logic [KEY_W-1:0] key_pool[POOL_MAX];
  int               fail_count = 0;
  int               cycles = 0;
  // While set, neither side idles: keys go back to back and results drain at once.
  bit               calm;

  space_saving_heavy_hitters_unit dut (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key          (key),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .evicted      (evicted),
    .evicted_key  (evicted_key),
    .key_count    (key_count),
    .reported     (reported),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count one key into the shadow table and return what the block must report.
  function automatic outcome_t count_key(input logic [KEY_W-1:0] k);
    outcome_t         o;
    int               match_i;
    int               free_i;
    int               min_i;
    int               s;
    logic [CNT_W-1:0] c;
    match_i = -1;
    free_i  = -1;
    min_i   = -1;
    o       = '0;
    // First match, first free slot and lowest-slot minimum, all in one pass.
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_used[i]) begin
        if (match_i < 0 && slot_keys[i] == k) match_i = i;
        if (min_i < 0 || slot_counts[i] < slot_counts[min_i]) min_i = i;
      end else if (free_i < 0) begin
        free_i = i;
      end
    end
    if (match_i >= 0) begin
      s     = match_i;
      o.hit = 1'b1;
      c     = (slot_counts[s] == '1) ? slot_counts[s] : slot_counts[s] + 1'b1;
    end else if (free_i >= 0) begin
      s            = free_i;
      c            = 1;
      slot_used[s] = 1'b1;
    end else begin
      // Replace the minimum: the newcomer inherits its count plus one.
      s             = min_i;
      o.evicted     = 1'b1;
      o.evicted_key = slot_keys[s];
      c             = (slot_counts[s] == '1) ? slot_counts[s] : slot_counts[s] + 1'b1;
    end
    slot_keys[s]   = k;
    slot_counts[s] = c;
    o.key_count    = c;
    if (c > report_limit) begin
      o.reported   = 1'b1;
      slot_used[s] = 1'b0;
    end
    return o;
  endfunction

  // Mostly keys from the pool, skewed toward its low end so some become heavy
  // hitters; the rest are fresh random words that force inserts and evictions.
  function automatic logic [KEY_W-1:0] pick_key(input int pool_n);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return $urandom;
    return key_pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
  endfunction

  // Send one key word: idle for a random gap, present it, hold it until taken,
  // then record the predicted outcome.
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      @(negedge clk);
      key_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    key_valid <= 1'b1;
    key       <= k;
    do @(posedge clk); while (key_stall);
    pending_outcomes.push_back(count_key(k));
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    key_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2 * ITEM_CYCLES) @(posedge clk);
  endtask

  // Write the report threshold while the block is idle.
  task automatic set_threshold(input logic [CNT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    report_limit = v;
  endtask

  // Extreme keys, first inserts and repeat hits under the reset threshold.
  task automatic test_key_extremes();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'h0000_0000);
  endtask

  // With the threshold at zero every updated key is reported and freed at once,
  // tracked or not.
  task automatic test_zero_threshold();
    set_threshold(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0BAD_F00D);
  endtask

  // A key reported under a small threshold frees its slot; the next untracked
  // key takes the lowest free slot and the old key starts over at one.
  task automatic test_freed_slot_reuse();
    set_threshold(32'h0000_0002);
    send_key(32'h1111_1111);
    send_key(32'h1111_1111);
    send_key(32'h1111_1111);
    send_key(32'h2222_2222);
    send_key(32'h1111_1111);
    send_key(32'h2222_2222);
  endtask

  // Skewed random streams, one phase per threshold setting. Pools wider than
  // the table can fill it and force evictions; the narrow pool fits in the table.
  task automatic test_random_stream();
    logic [CNT_W-1:0] limits [PHASES];
    int               pool_n [PHASES];
    bit               quiet  [PHASES];
    limits[0] = 32'hFFFF_FFFF;            pool_n[0] = 96;  quiet[0] = 1'b0;
    limits[1] = 32'h0000_0000;            pool_n[1] = 96;  quiet[1] = 1'b0;
    limits[2] = $urandom_range(2, 40);    pool_n[2] = 96;  quiet[2] = 1'b1;
    limits[3] = 32'h0000_0001;            pool_n[3] = 48;  quiet[3] = 1'b0;
    limits[4] = $urandom;                 pool_n[4] = 128; quiet[4] = 1'b0;
    limits[5] = $urandom_range(5, 200);   pool_n[5] = 80;  quiet[5] = 1'b0;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      set_threshold(limits[p]);
      calm = quiet[p];
      for (int n = 0; n < PHASE_KEYS; n++) send_key(pick_key(pool_n[p]));
    end
    calm = 1'b0;
  endtask

  // Result side: per word draw a stall length; raise stall early so it also
  // lands while the scan runs, and hold it once the result shows up.
  initial begin : result_side
    int hold;
    result_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        result_stall <= 1'b1;
        do @(posedge clk); while (!result_valid);
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_outcomes
    outcome_t got;
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {hit, evicted, evicted_key, key_count, reported};
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t: result with nothing pending: hit %b evicted %b ek %h cnt %h rep %b",
                   $realtime, got.hit, got.evicted, got.evicted_key, got.key_count,
                   got.reported);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit || got.evicted !== want.evicted ||
            got.evicted_key !== want.evicted_key || got.key_count !== want.key_count ||
            got.reported !== want.reported) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("%0t: mismatch", $realtime);
            $display("  expected hit %b evicted %b ek %h cnt %h rep %b",
                     want.hit, want.evicted, want.evicted_key, want.key_count, want.reported);
            $display("  actual   hit %b evicted %b ek %h cnt %h rep %b",
                     got.hit, got.evicted, got.evicted_key, got.key_count, got.reported);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run
    rst        = 1'b1;
    key_valid  = 1'b0;
    key        = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    calm       = 1'b0;
    // Shadow reset: nothing tracked, threshold all ones.
    for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
    report_limit = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_key_extremes();
    test_zero_threshold();
    test_freed_slot_reuse();
    test_random_stream();

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### space_saving_heavy_hitters_unit.f
+incdir+rtl
rtl/sshh_pkg.sv
rtl/sshh_table.sv
rtl/space_saving_heavy_hitters_unit.sv
verif/tb.sv
